// ===== rtl/hdp_pkg.sv =====
// HTTP date parser package: parse phases, date form codes, fields record.
// No dependencies; used by all hdp modules.
`timescale 1ns / 1ps
`default_nettype none
package hdp_pkg;

  typedef enum logic [4:0] {
    PH_WD0, PH_WD1, PH_WD2, PH_AFTWD, PH_WORD, PH_CSP, PH_DAY, PH_MO0,
    PH_MO1, PH_MO2, PH_MOSEP, PH_YEAR, PH_HOUR, PH_MIN, PH_SEC, PH_G,
    PH_M, PH_T, PH_AYEAR, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    FMT_UNDECIDED, FMT_RFC1123, FMT_RFC850, FMT_ASCTIME
  } fmt_t;

  localparam int SecW = 39;
  localparam int QueueDepth = 2;

  // Fields of one parsed string, handed from front to back.
  typedef struct packed {
    logic       ok;
    fmt_t       fmt;
    logic [3:0] month;
    logic [6:0] day;
    logic [13:0] year;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
  } fields_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)
      || c == 8'h5f;
  endfunction

  function automatic logic is_day_name(input logic [23:0] n);
    return n == 24'h53756e || n == 24'h4d6f6e || n == 24'h547565 || n == 24'h576564
      || n == 24'h546875 || n == 24'h467269 || n == 24'h536174;
  endfunction

  // Month lookup: bit 4 set when found, low bits give the index.
  function automatic logic [4:0] month_lookup(input logic [23:0] n);
    logic [4:0] r;
    r = 5'd0;
    case (n)
      24'h4a616e: r = 5'h10;
      24'h466562: r = 5'h11;
      24'h4d6172: r = 5'h12;
      24'h417072: r = 5'h13;
      24'h4d6179: r = 5'h14;
      24'h4a756e: r = 5'h15;
      24'h4a756c: r = 5'h16;
      24'h417567: r = 5'h17;
      24'h536570: r = 5'h18;
      24'h4f6374: r = 5'h19;
      24'h4e6f76: r = 5'h1a;
      24'h446563: r = 5'h1b;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hdp_front.sv =====
// Front end: per-byte character scanner of the HTTP date grammar.
// Depends on hdp_pkg; emits one fields_t record per string.
`timescale 1ns / 1ps
`default_nettype none
module hdp_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       ch,
  input  wire logic             last,
  input  wire logic             in_fire,
  output hdp_pkg::fields_t      rec,
  output logic                  rec_valid
);

  hdp_pkg::phase_t ph, ph_next;
  hdp_pkg::fmt_t   fmt, fmt_next;
  logic [23:0] letters, letters_next;
  logic [3:0]  month, month_next;
  logic [2:0]  dcnt, dcnt_next;
  logic [6:0]  day, day_next, hour, hour_next, minute, minute_next, second, second_next;
  logic [13:0] year, year_next;
  logic        mis, mis_next;
  logic [3:0]  dig;
  logic [23:0] shifted;
  logic [4:0]  mlook;
  logic        dg;

  assign dig = ch[3:0];
  assign dg = hdp_pkg::is_digit(ch);
  assign shifted = {letters[15:0], ch};
  assign mlook = hdp_pkg::month_lookup(shifted);

  function automatic logic [6:0] acc7(input logic [6:0] v, input logic [3:0] d);
    return 7'(v * 7'd10 + 7'(d));
  endfunction

  always_comb begin
    ph_next = ph; fmt_next = fmt; letters_next = letters; month_next = month;
    dcnt_next = dcnt; day_next = day; hour_next = hour; minute_next = minute;
    second_next = second; year_next = year; mis_next = mis;
    if (!mis) begin
      case (ph)
        hdp_pkg::PH_WD0, hdp_pkg::PH_WD1, hdp_pkg::PH_MO0, hdp_pkg::PH_MO1: begin
          letters_next = shifted;
          ph_next = hdp_pkg::phase_t'(ph + 5'd1);
        end
        hdp_pkg::PH_WD2: begin
          letters_next = shifted;
          if (hdp_pkg::is_day_name(shifted)) ph_next = hdp_pkg::PH_AFTWD;
          else mis_next = 1'b1;
        end
        hdp_pkg::PH_AFTWD: begin
          if (ch == ",") ph_next = hdp_pkg::PH_CSP;
          else if (ch == " ") begin
            fmt_next = hdp_pkg::FMT_ASCTIME; ph_next = hdp_pkg::PH_MO0;
          end else if (hdp_pkg::is_word(ch)) begin
            fmt_next = hdp_pkg::FMT_RFC850; ph_next = hdp_pkg::PH_WORD;
          end else mis_next = 1'b1;
        end
        hdp_pkg::PH_WORD: begin
          if (ch == ",") ph_next = hdp_pkg::PH_CSP;
          else if (!hdp_pkg::is_word(ch)) mis_next = 1'b1;
        end
        hdp_pkg::PH_CSP: begin
          if (ch == " ") ph_next = hdp_pkg::PH_DAY; else mis_next = 1'b1;
        end
        hdp_pkg::PH_DAY: begin
          if (dg) begin
            if (dcnt >= 3'd2) mis_next = 1'b1;
            else begin day_next = acc7(day, dig); dcnt_next = dcnt + 3'd1; end
          end else if (fmt == hdp_pkg::FMT_ASCTIME) begin
            if (ch != " ") mis_next = 1'b1;
            else if (dcnt != 3'd0) begin dcnt_next = '0; ph_next = hdp_pkg::PH_HOUR; end
          end else if (dcnt != 3'd0 && ch == " " && fmt == hdp_pkg::FMT_UNDECIDED) begin
            fmt_next = hdp_pkg::FMT_RFC1123; dcnt_next = '0; ph_next = hdp_pkg::PH_MO0;
          end else if (dcnt != 3'd0 && ch == "-") begin
            fmt_next = hdp_pkg::FMT_RFC850; dcnt_next = '0; ph_next = hdp_pkg::PH_MO0;
          end else mis_next = 1'b1;
        end
        hdp_pkg::PH_MO2: begin
          letters_next = shifted;
          if (mlook[4]) begin
            month_next = mlook[3:0]; ph_next = hdp_pkg::PH_MOSEP;
          end else mis_next = 1'b1;
        end
        hdp_pkg::PH_MOSEP: begin
          if (fmt == hdp_pkg::FMT_RFC850) begin
            if (ch == "-") ph_next = hdp_pkg::PH_YEAR; else mis_next = 1'b1;
          end else if (ch == " ") begin
            ph_next = (fmt == hdp_pkg::FMT_ASCTIME) ? hdp_pkg::PH_DAY : hdp_pkg::PH_YEAR;
          end else mis_next = 1'b1;
        end
        hdp_pkg::PH_YEAR, hdp_pkg::PH_AYEAR: begin
          if (dg) begin
            if (dcnt >= ((fmt == hdp_pkg::FMT_RFC850) ? 3'd2 : 3'd4)) mis_next = 1'b1;
            else begin
              year_next = 14'(year * 14'd10 + 14'(dig));
              dcnt_next = dcnt + 3'd1;
              if (ph == hdp_pkg::PH_AYEAR && dcnt == 3'd3) ph_next = hdp_pkg::PH_DONE;
            end
          end else if (ph == hdp_pkg::PH_YEAR && ch == " " &&
                       ((fmt == hdp_pkg::FMT_RFC850) ? dcnt != 3'd0 : dcnt == 3'd4)) begin
            dcnt_next = '0; ph_next = hdp_pkg::PH_HOUR;
          end else mis_next = 1'b1;
        end
        hdp_pkg::PH_HOUR, hdp_pkg::PH_MIN, hdp_pkg::PH_SEC: begin
          if (dg) begin
            if (dcnt >= 3'd2) mis_next = 1'b1;
            else begin
              dcnt_next = dcnt + 3'd1;
              if (ph == hdp_pkg::PH_HOUR) hour_next = acc7(hour, dig);
              else if (ph == hdp_pkg::PH_MIN) minute_next = acc7(minute, dig);
              else second_next = acc7(second, dig);
            end
          end else if (dcnt != 3'd0 && ph != hdp_pkg::PH_SEC && ch == ":") begin
            dcnt_next = '0;
            ph_next = (ph == hdp_pkg::PH_HOUR) ? hdp_pkg::PH_MIN : hdp_pkg::PH_SEC;
          end else if (dcnt != 3'd0 && ph == hdp_pkg::PH_SEC && ch == " ") begin
            dcnt_next = '0;
            ph_next = (fmt == hdp_pkg::FMT_ASCTIME) ? hdp_pkg::PH_AYEAR : hdp_pkg::PH_G;
          end else mis_next = 1'b1;
        end
        hdp_pkg::PH_G: if (ch == "G") ph_next = hdp_pkg::PH_M; else mis_next = 1'b1;
        hdp_pkg::PH_M: if (ch == "M") ph_next = hdp_pkg::PH_T; else mis_next = 1'b1;
        hdp_pkg::PH_T: if (ch == "T") ph_next = hdp_pkg::PH_DONE; else mis_next = 1'b1;
        default: mis_next = 1'b1;
      endcase
    end
  end

  always_comb begin
    rec.ok = !mis_next && ph_next == hdp_pkg::PH_DONE;
    rec.fmt = fmt_next;
    rec.month = month_next;
    rec.day = day_next;
    rec.year = year_next;
    rec.hour = hour_next;
    rec.minute = minute_next;
    rec.second = second_next;
    rec_valid = in_fire && last;
  end

  always_ff @(posedge clk) begin
    if (rst || (in_fire && last)) begin
      ph <= hdp_pkg::PH_WD0; fmt <= hdp_pkg::FMT_UNDECIDED; letters <= '0;
      month <= '0; dcnt <= '0; day <= '0; year <= '0; hour <= '0;
      minute <= '0; second <= '0; mis <= 1'b0;
    end else if (in_fire) begin
      ph <= ph_next; fmt <= fmt_next; letters <= letters_next; month <= month_next;
      dcnt <= dcnt_next; day <= day_next; year <= year_next; hour <= hour_next;
      minute <= minute_next; second <= second_next; mis <= mis_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hdp_queue.sv =====
// Small FIFO of parsed field records between front and back.
// Depends on hdp_pkg for fields_t.
`timescale 1ns / 1ps
`default_nettype none
module hdp_queue #(
  parameter int Depth = hdp_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  hdp_pkg::fields_t wr_data,
  input  wire logic        wr_en,
  output logic             full,
  output hdp_pkg::fields_t rd_data,
  output logic             rd_valid,
  input  wire logic        rd_en
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  hdp_pkg::fields_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full = cnt == (AW+1)'(Depth);
  assign rd_valid = cnt != '0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr_en) wp <= inc(wp);
      if (rd_en) rp <= inc(rp);
      cnt <= cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hdp_back.sv =====
// Back end: turns a fields record into epoch seconds over a short pipeline.
// Depends on hdp_pkg; reads hdp_queue, drives the output register.
`timescale 1ns / 1ps
`default_nettype none
module hdp_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  hdp_pkg::fields_t               rec,
  input  wire logic                      rec_valid,
  output logic                           rec_take,
  output logic                           valid_res,
  output logic signed [hdp_pkg::SecW-1:0] seconds,
  output logic                           out_valid,
  input  wire logic                      out_ready
);

  // Stage 1: era and day of year. Stage 2: days from civil date.
  // Stage 3: day*86400 + time. Stage 4: out.
  logic        s1_v, s2_v, s3_v;
  logic        s1_ok, s2_ok, s3_ok;
  logic [13:0] s1_y;
  logic [4:0]  s1_era;
  logic [8:0]  s1_doy;
  logic [6:0]  s1_day;
  logic [18:0] s1_tod, s2_tod;
  logic signed [23:0] s2_days;
  logic signed [hdp_pkg::SecW-1:0] s3_sec;
  logic        adv1, adv2, adv3, adv4;

  logic [14:0] yr;
  logic [15:0] y;
  logic [3:0]  mon, mp;
  logic [26:0] era_prod;
  logic [4:0]  era_c;
  logic [8:0]  doy_c;
  logic [18:0] tod_c;
  logic [8:0]  yoe;
  logic [1:0]  ycent;
  logic signed [23:0] days_c;

  // Day of year of the first of each month, counted from March.
  function automatic logic [8:0] doy_of(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  always_comb begin
    yr = {1'b0, rec.year} + ((rec.fmt == hdp_pkg::FMT_RFC850) ? 15'd1900 : 15'd0);
    mon = rec.month + 4'd1;
    y = 16'(yr) + 16'd400 - ((mon < 4'd3) ? 16'd1 : 16'd0);
    // y / 400 by reciprocal; exact for y below 12800, as era_c holds five bits
    era_prod = 27'(y) * 27'd5243;
    era_c = era_prod[25:21];
    mp = (mon >= 4'd3) ? mon - 4'd3 : mon + 4'd9;
    doy_c = doy_of(mp);
    tod_c = 19'(rec.hour) * 19'd3600 + 19'(rec.minute) * 19'd60 + 19'(rec.second);
  end

  always_comb begin
    yoe = 9'(16'(s1_y) - 16'(s1_era) * 16'd400);
    if (yoe >= 9'd300) ycent = 2'd3;
    else if (yoe >= 9'd200) ycent = 2'd2;
    else if (yoe >= 9'd100) ycent = 2'd1;
    else ycent = 2'd0;
    days_c = 24'(s1_era) * 24'sd146097 + 24'(yoe) * 24'sd365 + 24'(yoe[8:2])
           - 24'(ycent) + 24'(s1_doy) - 24'sd719468 - 24'sd146097
           + 24'(s1_day) - 24'sd1;
  end

  assign adv4 = !out_valid || out_ready;
  assign adv3 = !s3_v || adv4;
  assign adv2 = !s2_v || adv3;
  assign adv1 = !s1_v || adv2;
  assign rec_take = rec_valid && adv1;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_ok <= rec.ok; s1_y <= y[13:0]; s1_era <= era_c; s1_doy <= doy_c;
      s1_day <= rec.day; s1_tod <= tod_c;
    end
    if (adv2) begin
      s2_ok <= s1_ok; s2_days <= days_c; s2_tod <= s1_tod;
    end
    if (adv3) begin
      s3_ok <= s2_ok;
      s3_sec <= s2_ok ? hdp_pkg::SecW'(s2_days * 39'sd86400 + $signed({1'b0, s2_tod}))
                      : '1;
    end
    if (adv4 && s3_v) begin
      valid_res <= s3_ok; seconds <= s3_sec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (adv1) s1_v <= rec_valid;
      if (adv2) s2_v <= s1_v;
      if (adv3) s3_v <= s2_v;
      if (adv4) out_valid <= s3_v;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/http_date_parser_unit.sv =====
// HTTP date parser top level: front scanner, field queue, epoch back end.
// Depends on hdp_pkg, hdp_front, hdp_queue, hdp_back.
//
// Usage: the in channel takes one character (ch) per request, last set on
// the final character of a date string (RFC1123, RFC850 or asctime form).
// One result request leaves on the out channel per string: valid_res and
// seconds since 1970-01-01 UTC, or valid_res 0 and seconds -1.
// Throughput: one character per cycle; the scanner updates its state in
// the cycle a character is accepted. The record of a string is written to
// the field queue on the edge that accepts its last character, then passes
// the era and day-of-year stage, days stage, seconds multiply stage and
// output register before out_valid is raised.
// The scanner and the back end are parted by a QueueDepth-entry queue, so
// input keeps flowing while a result waits; the input stalls only when the
// queue is full on a last character, i.e. after several back-to-back short
// strings with the receiver stalled.
// Reset (rst, synchronous) returns the scanner to start of string and
// empties queue and pipeline.
`timescale 1ns / 1ps
`default_nettype none
module http_date_parser_unit #(
  parameter int QueueDepth = hdp_pkg::QueueDepth
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 ch,
  input  wire logic                       last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            valid_res,
  output logic signed [hdp_pkg::SecW-1:0] seconds
);

  hdp_pkg::fields_t frec, qrec;
  logic frec_valid, qfull, qvalid, qtake, in_fire;

  // Only a last character writes the queue, so others never wait.
  assign in_ready = !qfull || !last;
  assign in_fire = in_valid && in_ready;

  hdp_front u_front (
    .clk(clk), .rst(rst), .ch(ch), .last(last), .in_fire(in_fire),
    .rec(frec), .rec_valid(frec_valid)
  );

  hdp_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst), .wr_data(frec), .wr_en(frec_valid), .full(qfull),
    .rd_data(qrec), .rd_valid(qvalid), .rd_en(qtake)
  );

  hdp_back u_back (
    .clk(clk), .rst(rst), .rec(qrec), .rec_valid(qvalid), .rec_take(qtake),
    .valid_res(valid_res), .seconds(seconds), .out_valid(out_valid),
    .out_ready(out_ready)
  );

endmodule
`default_nettype wire
